>>> rtl/dqi_pkg.sv
// Shared types and constants for the indexed double-ended queue.
package dqi_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // The remainder unit retires one dividend bit per cycle.
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

  // Request codes.
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> rtl/dqi_if.sv
// Valid/ready channel interfaces for the request and result sides of the queue.
interface dqi_in_if;
  logic                               valid;
  logic                               ready;
  logic        [dqi_pkg::OP_W-1:0]    op;
  logic signed [dqi_pkg::DATA_W-1:0]  data_in;
  logic signed [dqi_pkg::DATA_W-1:0]  position;

  modport source (output valid, output op, output data_in, output position, input ready);
  modport sink   (input valid, input op, input data_in, input position, output ready);
endinterface

interface dqi_out_if #(
  parameter int CNT_W = 11
);
  logic                               valid;
  logic                               ready;
  logic signed [dqi_pkg::DATA_W-1:0]  data_out;
  logic        [CNT_W-1:0]            count_now;
  logic        [dqi_pkg::ST_W-1:0]    status;

  modport source (output valid, output data_out, output count_now, output status, input ready);
  modport sink   (input valid, input data_out, input count_now, input status, output ready);
endinterface

>>> rtl/dqi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dqi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/double_ended_queue_indexed.sv
// Bounded double-ended queue of signed 32-bit words, kept in a ring buffer RAM.
// Requests arrive on in_ch (valid/ready): op selects push back/front, pop
// back/front, read front/back, read at a signed index, or clear. Each request
// yields exactly one result item on out_ch: the word read (zero unless a read),
// the length after the request, and a status (ok, empty, full).
// The block takes one request at a time; in_ch.ready is high only while idle.
// Push, pop and clear pass from acceptance through the execute state to the
// done state, which loads the result register; read front and read back add
// an address state for the RAM read; read index first reduces the signed index
// modulo the current length by a restoring remainder unit that handles one
// dividend bit per cycle, then a sign fix-up and the RAM read follow. The block
// is ready again in the same cycle in which a result is registered.
// The result register holds a finished item until out_ch.ready takes it; a new
// request may be accepted meanwhile, and its result waits in the sequencer
// until the register is free.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; the stored words are not cleared and are never read before written.
module double_ended_queue_indexed #(
  parameter int DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  dqi_in_if.sink    in_ch,
  dqi_out_if.source out_ch
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_OFF = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ONE_OFF  = CNT_W'(1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_ADDR = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Control registers.
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working and result registers.
  logic [dqi_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [dqi_pkg::DATA_W-1:0]    word_r, word_nxt;
  logic                          neg_r, neg_nxt;
  logic [dqi_pkg::DATA_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic [dqi_pkg::DIV_CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]              off_r, off_nxt;
  logic [dqi_pkg::ST_W-1:0]      status_r, status_nxt;
  logic                          rd_res_r, rd_res_nxt;
  logic [dqi_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [CNT_W-1:0]              out_count_r, out_count_nxt;
  logic [dqi_pkg::ST_W-1:0]      out_status_r, out_status_nxt;

  // Shared datapath.
  logic [CNT_W-1:0]           off_sel;
  logic [CNT_W:0]             slot_sum;
  logic [CNT_W:0]             slot_wrap;
  logic [AW-1:0]              slot_addr;
  logic [CNT_W:0]             trial;
  logic [CNT_W:0]             len_x;
  logic [CNT_W:0]             rem_step;
  logic [dqi_pkg::DATA_W-1:0] pos_mag;
  logic                       wr_en;
  logic                       rd_en;
  logic [dqi_pkg::DATA_W-1:0] rd_data;
  logic                       empty;
  logic                       full;

  assign empty = (count_r == '0);
  assign full  = (count_r == DEPTH_C);

  // Ring slot of the word at a given offset from the front.
  assign slot_sum  = {1'b0, CNT_W'(front_r)} + {1'b0, off_sel};
  assign slot_wrap = (slot_sum >= DEPTH_X) ? (slot_sum - DEPTH_X) : slot_sum;
  assign slot_addr = slot_wrap[AW-1:0];

  // One restoring remainder step: bring in the next dividend bit.
  assign trial    = {rem_r, quo_r[dqi_pkg::DATA_W-1]};
  assign len_x    = {1'b0, count_r};
  assign rem_step = (trial >= len_x) ? (trial - len_x) : trial;

  // Magnitude of the index; the most negative value maps to itself unsigned.
  assign pos_mag = in_ch.position[dqi_pkg::DATA_W-1] ?
                   (~in_ch.position + 1'b1) : in_ch.position;

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    op_nxt         = op_r;
    word_nxt       = word_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    off_nxt        = off_r;
    status_nxt     = status_r;
    rd_res_nxt     = rd_res_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    off_sel        = off_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.op;
          word_nxt   = in_ch.data_in;
          neg_nxt    = in_ch.position[dqi_pkg::DATA_W-1];
          quo_nxt    = pos_mag;
          status_nxt = dqi_pkg::ST_OK;
          rd_res_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          dqi_pkg::OP_PUSH_BACK: begin
            off_sel = count_r;
            if (full) begin
              status_nxt = dqi_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + ONE_OFF;
            end
          end
          dqi_pkg::OP_PUSH_FRONT: begin
            off_sel = LAST_OFF;
            if (full) begin
              status_nxt = dqi_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              front_nxt = slot_addr;
              count_nxt = count_r + ONE_OFF;
            end
          end
          dqi_pkg::OP_POP_BACK: begin
            if (empty) begin
              status_nxt = dqi_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - ONE_OFF;
            end
          end
          dqi_pkg::OP_POP_FRONT: begin
            off_sel = ONE_OFF;
            if (empty) begin
              status_nxt = dqi_pkg::ST_EMPTY;
            end else begin
              front_nxt = slot_addr;
              count_nxt = count_r - ONE_OFF;
            end
          end
          dqi_pkg::OP_READ_FRONT: begin
            if (empty) begin
              status_nxt = dqi_pkg::ST_EMPTY;
            end else begin
              off_nxt    = '0;
              rd_res_nxt = 1'b1;
              state_nxt  = S_ADDR;
            end
          end
          dqi_pkg::OP_READ_BACK: begin
            if (empty) begin
              status_nxt = dqi_pkg::ST_EMPTY;
            end else begin
              off_nxt    = count_r - ONE_OFF;
              rd_res_nxt = 1'b1;
              state_nxt  = S_ADDR;
            end
          end
          dqi_pkg::OP_READ_INDEX: begin
            if (empty) begin
              status_nxt = dqi_pkg::ST_EMPTY;
            end else begin
              rem_nxt   = '0;
              step_nxt  = dqi_pkg::DIV_LAST;
              state_nxt = S_DIV;
            end
          end
          default: begin
            // Clear: the stored words stay, only the bookkeeping resets.
            count_nxt = '0;
            front_nxt = '0;
          end
        endcase
      end

      S_DIV: begin
        rem_nxt  = rem_step[CNT_W-1:0];
        quo_nxt  = quo_r << 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        // A negative index with a nonzero remainder counts from the back.
        off_nxt    = (neg_r && (rem_r != '0)) ? (count_r - rem_r) : rem_r;
        rd_res_nxt = 1'b1;
        state_nxt  = S_ADDR;
      end

      S_ADDR: begin
        rd_en     = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = rd_res_r ? rd_data : '0;
          out_count_nxt  = count_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    word_r       <= word_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    off_r        <= off_nxt;
    status_r     <= status_nxt;
    rd_res_r     <= rd_res_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // Word storage.
  dqi_ram #(
    .WIDTH (dqi_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_addr),
    .wr_data (word_r),
    .rd_en   (rd_en),
    .rd_addr (slot_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.count_now = out_count_r;
  assign out_ch.status    = out_status_r;

endmodule
